// ===== design/ssme_pkg.sv =====
// ----------------------------------------------------------------------------
// ssme_pkg: seven-segment message encoder package
// Command codes, character codes, font ROM, pipeline payload types and the
// decimal digit step shared by the encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ssme_pkg;

   typedef enum logic [2:0] {
      OP_MESSAGE = 3'd0,
      OP_NUMBER  = 3'd1,
      OP_ERROR   = 3'd2,
      OP_PIN     = 3'd3,
      OP_VERSION = 3'd4
   } op_type;

   localparam int CHAR_COUNT   = 5;
   localparam int POS_WIDTH    = 3;
   localparam int MSG_WIDTH    = 30;
   localparam int REM_WIDTH    = 17;
   localparam int Q_WIDTH      = 16;
   localparam int PROD_WIDTH   = 55;
   localparam int RECIP_SHIFT  = 39;
   localparam int DIGIT_STAGES = 4;

   typedef logic [5:0]           code_type;
   typedef logic [7:0]           seg_type;
   typedef logic [3:0]           digit_type;
   typedef logic [REM_WIDTH-1:0] rem_val_type;
   typedef logic [POS_WIDTH-1:0] pos_type;

   localparam pos_type LAST_POS = pos_type'(CHAR_COUNT - 1);

   // floor(x / 3125) == (x * RECIP_MULT) >> 39 for every 27-bit x
   localparam logic [27:0]  RECIP_MULT = 28'd175921861;
   localparam rem_val_type  DEC_SPAN   = 17'd100000;

   localparam logic [DIGIT_STAGES-1:0][REM_WIDTH-1:0] DIGIT_WEIGHTS =
      {17'd10, 17'd100, 17'd1000, 17'd10000};

   localparam code_type    CODE_SPACE    = 6'd10;
   localparam code_type    CODE_MINUS    = 6'd11;
   localparam code_type    CODE_E        = 6'd20;
   localparam code_type    CODE_I        = 6'd24;
   localparam code_type    CODE_O        = 6'd30;
   localparam code_type    CODE_R        = 6'd33;
   localparam logic [7:0]  CODE_LETTER_A = 8'd16;

   typedef struct packed {
      op_type                 op;
      logic [MSG_WIDTH-1:0]   msg;
      rem_val_type            rem;
   } rem_type;

   typedef struct packed {
      op_type                            op;
      logic [MSG_WIDTH-1:0]              msg;
      logic [CHAR_COUNT-1:0][3:0]        digits;
   } code_src_type;

   typedef logic [CHAR_COUNT-1:0][7:0] seg_row_type;

   typedef struct packed {
      digit_type   digit;
      rem_val_type rem;
   } digit_step_type;

   // one decimal digit off the top: nine parallel compares against k*weight
   function automatic digit_step_type digit_step(input rem_val_type rem,
                                                 input rem_val_type weight);
      digit_step_type res;
      rem_val_type    mult_w;
      rem_val_type    sub;
      mult_w    = '0;
      sub       = '0;
      res.digit = '0;
      for (int k = 1; k <= 9; k++) begin
         mult_w = mult_w + weight;
         if (rem >= mult_w) begin
            res.digit = digit_type'(k);
            sub       = mult_w;
         end
      end
      res.rem = rem - sub;
      return res;
   endfunction

   // font ROM, .gfedcba; codes past the font are blank
   function automatic seg_type glyph_of(input code_type code);
      seg_type seg;
      case (code)
         6'd0:    seg = 8'h3F;
         6'd1:    seg = 8'h06;
         6'd2:    seg = 8'h5B;
         6'd3:    seg = 8'h4F;
         6'd4:    seg = 8'h66;
         6'd5:    seg = 8'h6D;
         6'd6:    seg = 8'h7D;
         6'd7:    seg = 8'h07;
         6'd8:    seg = 8'h7F;
         6'd9:    seg = 8'h6F;
         6'd11:   seg = 8'h40;
         6'd16:   seg = 8'h77;
         6'd17:   seg = 8'h7C;
         6'd18:   seg = 8'h39;
         6'd19:   seg = 8'h5E;
         6'd20:   seg = 8'h79;
         6'd21:   seg = 8'h71;
         6'd22:   seg = 8'h3D;
         6'd23:   seg = 8'h76;
         6'd24:   seg = 8'h30;
         6'd25:   seg = 8'h0E;
         6'd26:   seg = 8'h7A;
         6'd27:   seg = 8'h38;
         6'd29:   seg = 8'h54;
         6'd30:   seg = 8'h3F;
         6'd31:   seg = 8'h73;
         6'd33:   seg = 8'h50;
         6'd34:   seg = 8'h6D;
         6'd35:   seg = 8'h78;
         6'd36:   seg = 8'h3E;
         6'd40:   seg = 8'h72;
         6'd41:   seg = 8'h5B;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

// ===== design/ssme_req_if.sv =====
// ----------------------------------------------------------------------------
// ssme_req_if: command channel
// Valid/ready channel carrying one display command per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssme_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [31:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

// ===== design/ssme_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ssme_rsp_if: segment byte channel
// Valid/ready channel carrying one segment byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssme_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] segments;
   logic [2:0] position;
   logic       last;

   modport source (output valid, output segments, output position, output last,
                   input ready);
   modport sink   (input valid, input segments, input position, input last,
                   output ready);
endinterface

`default_nettype wire

// ===== design/ssme_front.sv =====
// ----------------------------------------------------------------------------
// ssme_front: command intake and modulo-100000 reduction
// Three stages: reciprocal multiply, quotient back-multiply, subtract.
// Illegal commands are taken and dropped here.
// ----------------------------------------------------------------------------
`default_nettype none

module ssme_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [2:0]            in_op,
   input  logic [31:0]           in_value,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ssme_pkg::rem_type     out_data
);

   logic                                 s1_valid_ff, s1_valid_in, s1_ready;
   ssme_pkg::op_type                     s1_op_ff, s1_op_in;
   logic [ssme_pkg::MSG_WIDTH-1:0]       s1_msg_ff;
   logic [ssme_pkg::PROD_WIDTH-1:0]      s1_prod_ff, s1_prod_in;

   logic                                 s2_valid_ff, s2_ready;
   ssme_pkg::op_type                     s2_op_ff;
   logic [ssme_pkg::MSG_WIDTH-1:0]       s2_msg_ff;
   ssme_pkg::rem_val_type                s2_qm_ff, s2_qm_in;
   logic [ssme_pkg::Q_WIDTH-1:0]         s2_quot;

   logic                                 s3_valid_ff, s3_ready;
   ssme_pkg::rem_type                    s3_data_ff, s3_data_in;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      s1_op_in    = ssme_pkg::op_type'(in_op);
      s1_valid_in = in_valid && (in_op <= ssme_pkg::OP_VERSION);
      s1_prod_in  = ssme_pkg::PROD_WIDTH'(in_value[31:5])
                  * ssme_pkg::PROD_WIDTH'(ssme_pkg::RECIP_MULT);
   end

   always_comb begin
      s2_quot  = s1_prod_ff[ssme_pkg::RECIP_SHIFT +: ssme_pkg::Q_WIDTH];
      s2_qm_in = ssme_pkg::rem_val_type'({1'b0, s2_quot}) * ssme_pkg::DEC_SPAN;
   end

   always_comb begin
      s3_data_in.op  = s2_op_ff;
      s3_data_in.msg = s2_msg_ff;
      if (s2_op_ff == ssme_pkg::OP_NUMBER) begin
         s3_data_in.rem = s2_msg_ff[ssme_pkg::REM_WIDTH-1:0] - s2_qm_ff;
      end else begin
         s3_data_in.rem = ssme_pkg::rem_val_type'(s2_msg_ff[7:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_op_ff   <= s1_op_in;
         s1_msg_ff  <= in_value[ssme_pkg::MSG_WIDTH-1:0];
         s1_prod_ff <= s1_prod_in;
      end
      if (s2_ready) begin
         s2_op_ff  <= s1_op_ff;
         s2_msg_ff <= s1_msg_ff;
         s2_qm_ff  <= s2_qm_in;
      end
      if (s3_ready) begin
         s3_data_ff <= s3_data_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_data_ff;

`ifndef SYNTH
   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_data.op == ssme_pkg::OP_NUMBER) |->
         (out_data.rem < ssme_pkg::DEC_SPAN))
      else $error("remainder out of decimal range");
   a_no_illegal_op: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_op_ff <= ssme_pkg::OP_VERSION))
      else $error("illegal command entered pipeline");
`endif

endmodule

`default_nettype wire

// ===== design/ssme_digits.sv =====
// ----------------------------------------------------------------------------
// ssme_digits: decimal digit pipeline
// Four stages peel off the ten-thousands, thousands, hundreds and tens digit;
// the remainder left is the units digit.
// ----------------------------------------------------------------------------
`default_nettype none

module ssme_digits (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  ssme_pkg::rem_type         in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output ssme_pkg::code_src_type    out_data
);

   typedef struct packed {
      ssme_pkg::op_type                          op;
      logic [ssme_pkg::MSG_WIDTH-1:0]            msg;
      ssme_pkg::rem_val_type                     rem;
      logic [ssme_pkg::CHAR_COUNT-1:0][3:0]      digits;
   } dig_type;

   localparam int N = ssme_pkg::DIGIT_STAGES;

   logic [N-1:0]            valid_ff;
   logic [N-1:0]            stage_ready;
   logic [N-1:0]            src_valid;
   dig_type                 data_ff [N];
   dig_type                 data_in [N];
   dig_type                 src_data [N];
   ssme_pkg::digit_step_type step [N];

   always_comb begin
      for (int i = 0; i < N; i++) begin
         if (i == 0) begin
            src_valid[i]       = in_valid;
            src_data[i].op     = in_data.op;
            src_data[i].msg    = in_data.msg;
            src_data[i].rem    = in_data.rem;
            src_data[i].digits = '0;
         end else begin
            src_valid[i] = valid_ff[i-1];
            src_data[i]  = data_ff[i-1];
         end
         step[i]               = ssme_pkg::digit_step(src_data[i].rem,
                                                      ssme_pkg::DIGIT_WEIGHTS[i]);
         data_in[i]            = src_data[i];
         data_in[i].rem        = step[i].rem;
         data_in[i].digits[i]  = step[i].digit;
      end
   end

   always_comb begin
      stage_ready[N-1] = !valid_ff[N-1] || out_ready;
      for (int i = N - 2; i >= 0; i--) begin
         stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end
   end

   assign in_ready = stage_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < N; i++) begin
            if (stage_ready[i]) begin
               valid_ff[i] <= src_valid[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         if (stage_ready[i]) begin
            data_ff[i] <= data_in[i];
         end
      end
   end

   always_comb begin
      out_valid     = valid_ff[N-1];
      out_data.op   = data_ff[N-1].op;
      out_data.msg  = data_ff[N-1].msg;
      out_data.digits = data_ff[N-1].digits;
      out_data.digits[ssme_pkg::CHAR_COUNT-1] = data_ff[N-1].rem[3:0];
   end

`ifndef SYNTH
   a_digits_decimal: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_data.digits[0] <= 4'd9 && out_data.digits[1] <= 4'd9 &&
                     out_data.digits[2] <= 4'd9 && out_data.digits[3] <= 4'd9 &&
                     out_data.digits[4] <= 4'd9))
      else $error("digit outside 0..9");
`endif

endmodule

`default_nettype wire

// ===== design/ssme_glyph.sv =====
// ----------------------------------------------------------------------------
// ssme_glyph: character code build and font lookup
// Forms the five character codes for the command and maps each through the
// font ROM into one registered row of segment bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module ssme_glyph (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  ssme_pkg::code_src_type    in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output ssme_pkg::seg_row_type     out_data
);

   logic                                        valid_ff;
   ssme_pkg::seg_row_type                       seg_ff, seg_in;
   ssme_pkg::code_type [ssme_pkg::CHAR_COUNT-1:0] codes;
   logic [7:0]                                  pin_sum;
   ssme_pkg::code_type                          pin_code;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      pin_sum = ssme_pkg::CODE_LETTER_A + in_data.msg[7:0];
      if (pin_sum[7:6] != 2'b00) begin
         pin_code = ssme_pkg::CODE_SPACE;
      end else begin
         pin_code = pin_sum[5:0];
      end
      for (int k = 0; k < ssme_pkg::CHAR_COUNT; k++) begin
         codes[k] = ssme_pkg::CODE_SPACE;
      end
      case (in_data.op)
         ssme_pkg::OP_MESSAGE: begin
            for (int k = 0; k < ssme_pkg::CHAR_COUNT; k++) begin
               codes[k] = in_data.msg[6*k +: 6];
            end
         end
         ssme_pkg::OP_NUMBER: begin
            for (int k = 0; k < ssme_pkg::CHAR_COUNT; k++) begin
               codes[k] = {2'b00, in_data.digits[k]};
            end
         end
         ssme_pkg::OP_ERROR: begin
            codes[0] = ssme_pkg::CODE_E;
            codes[1] = ssme_pkg::CODE_R;
            codes[2] = ssme_pkg::CODE_R;
            codes[3] = {2'b00, in_data.digits[3]};
            codes[4] = {2'b00, in_data.digits[4]};
         end
         ssme_pkg::OP_PIN: begin
            codes[0] = ssme_pkg::CODE_I;
            codes[1] = ssme_pkg::CODE_O;
            codes[2] = ssme_pkg::CODE_MINUS;
            codes[3] = pin_code;
            codes[4] = ssme_pkg::CODE_SPACE;
         end
         ssme_pkg::OP_VERSION: begin
            codes[0] = ssme_pkg::CODE_R;
            codes[1] = ssme_pkg::CODE_SPACE;
            codes[2] = ssme_pkg::CODE_SPACE;
            codes[3] = {2'b00, in_data.digits[3]};
            codes[4] = {2'b00, in_data.digits[4]};
         end
         default: begin
            for (int k = 0; k < ssme_pkg::CHAR_COUNT; k++) begin
               codes[k] = ssme_pkg::CODE_SPACE;
            end
         end
      endcase
      for (int k = 0; k < ssme_pkg::CHAR_COUNT; k++) begin
         seg_in[k] = ssme_pkg::glyph_of(codes[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         seg_ff <= seg_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = seg_ff;

endmodule

`default_nettype wire

// ===== design/ssme_serializer.sv =====
// ----------------------------------------------------------------------------
// ssme_serializer: segment byte output stage
// Holds one row of five segment bytes and sends them one per transaction in
// shift order, flagging the fifth. A new row loads when idle or as the last byte leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module ssme_serializer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  ssme_pkg::seg_row_type     in_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_segments,
   output logic [2:0]                rsp_position,
   output logic                      rsp_last
);

   logic                    busy_ff, busy_in;
   ssme_pkg::pos_type       pos_ff, pos_in;
   ssme_pkg::seg_row_type   row_ff;
   logic                    is_last;
   logic                    load;

   assign is_last  = (pos_ff == ssme_pkg::LAST_POS);
   assign in_ready = !busy_ff || (rsp_ready && is_last);
   assign load     = in_valid && in_ready;

   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      if (load) begin
         busy_in = 1'b1;
         pos_in  = '0;
      end else if (busy_ff && rsp_ready) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         row_ff <= in_data;
      end
   end

   assign rsp_valid    = busy_ff;
   assign rsp_segments = row_ff[pos_ff];
   assign rsp_position = pos_ff;
   assign rsp_last     = busy_ff && is_last;

`ifndef SYNTH
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pos_ff <= ssme_pkg::LAST_POS))
      else $error("byte position past fifth character");
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=>
         (rsp_valid && pos_ff == 3'($past(pos_ff) + 3'd1)))
      else $error("byte position did not advance");
   a_load_start: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> (rsp_valid && pos_ff == '0))
      else $error("new row did not start at first byte");
`endif

endmodule

`default_nettype wire

// ===== design/seven_segment_message_encoder.sv =====
// ----------------------------------------------------------------------------
// seven_segment_message_encoder: display command to segment byte encoder
// Turns one display command into five seven-segment bytes in shift order.
// ----------------------------------------------------------------------------
// Each command on req_ch yields five bytes on rsp_ch (.gfedcba, dot always
// clear), positions 0 to 4, last set on the fifth. Commands pass an
// eight-stage pipeline (reciprocal multiply, back-multiply, subtract, four
// decimal digit stages, font lookup) into an output register that sends one
// byte per transaction, one byte per cycle while rsp_ch is ready; new
// commands keep entering the pipeline while earlier bytes are being sent.
// Up to eight commands can sit in the pipeline behind a stalled output.
// Commands with an unused op code (5 to 7) are taken and give no bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_message_encoder (
   input  logic          clock,
   input  logic          reset,
   ssme_req_if.sink      req_ch,
   ssme_rsp_if.source    rsp_ch
);

   logic                        rem_valid, rem_ready;
   ssme_pkg::rem_type           rem_data;
   logic                        src_valid, src_ready;
   ssme_pkg::code_src_type      src_data;
   logic                        row_valid, row_ready;
   ssme_pkg::seg_row_type       row_data;

   ssme_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_op     (req_ch.op),
      .in_value  (req_ch.value),
      .out_valid (rem_valid),
      .out_ready (rem_ready),
      .out_data  (rem_data)
   );

   ssme_digits u_digits (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rem_valid),
      .in_ready  (rem_ready),
      .in_data   (rem_data),
      .out_valid (src_valid),
      .out_ready (src_ready),
      .out_data  (src_data)
   );

   ssme_glyph u_glyph (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (src_valid),
      .in_ready  (src_ready),
      .in_data   (src_data),
      .out_valid (row_valid),
      .out_ready (row_ready),
      .out_data  (row_data)
   );

   ssme_serializer u_serializer (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (row_valid),
      .in_ready     (row_ready),
      .in_data      (row_data),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .rsp_segments (rsp_ch.segments),
      .rsp_position (rsp_ch.position),
      .rsp_last     (rsp_ch.last)
   );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: seven-segment message encoder regression
// Drives display commands of every mode into the encoder, with random gaps
// on both channels and one long output stall, and checks each segment byte
// against a scoreboard that predicts the five bytes of every display command.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          GLYPH_COUNT   = 42;
   localparam int          RANDOM_CMDS   = 255;
   localparam int          DRAIN_CYCLES  = 20;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0]  OP_SPARE_MID   = 3'd6;
   localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;

   typedef struct {
      ssme_pkg::seg_type segments;
      ssme_pkg::pos_type position;
      logic              last;
   } display_byte_type;

   class segment_scoreboard;
      display_byte_type  pending[$];
      int unsigned       mismatches;
      int unsigned       bytes_checked;
      ssme_pkg::seg_type font_bytes[GLYPH_COUNT];

      function new();
         font_bytes = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
                        8'h7F, 8'h6F, 8'h00, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00,
                        8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76,
                        8'h30, 8'h0E, 8'h7A, 8'h38, 8'h00, 8'h54, 8'h3F, 8'h73,
                        8'h00, 8'h50, 8'h6D, 8'h78, 8'h3E, 8'h00, 8'h00, 8'h00,
                        8'h72, 8'h5B};
         mismatches    = 0;
         bytes_checked = 0;
      endfunction

      function ssme_pkg::seg_type glyph(logic [7:0] code);
         return (code < GLYPH_COUNT) ? font_bytes[code] : 8'h00;
      endfunction

      // expands one accepted display command into its five expected bytes; unused op codes expect none
      function void note_command(logic [2:0] op, logic [31:0] value);
         logic [7:0]       codes[ssme_pkg::CHAR_COUNT];
         logic [7:0]       low8;
         int unsigned      divisor;
         display_byte_type exp_byte;
         low8    = value[7:0];
         divisor = 10000;
         case (op)
            ssme_pkg::OP_MESSAGE: begin
               for (int k = 0; k < ssme_pkg::CHAR_COUNT; k++)
                  codes[k] = {2'b00, value[6*k +: 6]};
            end
            ssme_pkg::OP_NUMBER: begin
               for (int k = 0; k < ssme_pkg::CHAR_COUNT; k++) begin
                  codes[k] = 8'((value / divisor) % 10);
                  divisor  = divisor / 10;
               end
            end
            ssme_pkg::OP_ERROR: begin
               codes[0] = {2'b00, ssme_pkg::CODE_E};
               codes[1] = {2'b00, ssme_pkg::CODE_R};
               codes[2] = {2'b00, ssme_pkg::CODE_R};
               codes[3] = (low8 / 8'd10) % 8'd10;
               codes[4] = low8 % 8'd10;
            end
            ssme_pkg::OP_PIN: begin
               codes[0] = {2'b00, ssme_pkg::CODE_I};
               codes[1] = {2'b00, ssme_pkg::CODE_O};
               codes[2] = {2'b00, ssme_pkg::CODE_MINUS};
               codes[3] = ssme_pkg::CODE_LETTER_A + low8;
               codes[4] = {2'b00, ssme_pkg::CODE_SPACE};
            end
            ssme_pkg::OP_VERSION: begin
               codes[0] = {2'b00, ssme_pkg::CODE_R};
               codes[1] = {2'b00, ssme_pkg::CODE_SPACE};
               codes[2] = {2'b00, ssme_pkg::CODE_SPACE};
               codes[3] = (low8 / 8'd10) % 8'd10;
               codes[4] = low8 % 8'd10;
            end
            default: return;
         endcase
         for (int k = 0; k < ssme_pkg::CHAR_COUNT; k++) begin
            exp_byte.segments = glyph(codes[k]);
            exp_byte.position = ssme_pkg::pos_type'(k);
            exp_byte.last     = (k == ssme_pkg::CHAR_COUNT - 1);
            pending.push_back(exp_byte);
         end
      endfunction

      function void check_byte(ssme_pkg::seg_type segments, ssme_pkg::pos_type position,
                               logic last);
         display_byte_type exp_byte;
         if (pending.size() == 0) begin
            $error("unexpected segment byte: segments %h position %0d last %0b",
                   segments, position, last);
            mismatches++;
            return;
         end
         exp_byte = pending.pop_front();
         bytes_checked++;
         if (segments !== exp_byte.segments) begin
            $error("segments: expected %h, actual %h", exp_byte.segments, segments);
            mismatches++;
         end
         if (position !== exp_byte.position) begin
            $error("position: expected %0d, actual %0d", exp_byte.position, position);
            mismatches++;
         end
         if (last !== exp_byte.last) begin
            $error("last: expected %0b, actual %0b", exp_byte.last, last);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   ssme_req_if req_ch ();
   ssme_rsp_if rsp_ch ();

   seven_segment_message_encoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   segment_scoreboard display_sb;
   int unsigned       cycle_count;
   int unsigned       commands_sent;
   int unsigned       commands_ignored;
   bit                steady;
   bit                hold_pending;
   bit                hold_seen;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("seven_segment_message_encoder regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         display_sb.check_byte(rsp_ch.segments, rsp_ch.position, rsp_ch.last);
   end

   // mostly short gaps, a few long ones; none in steady stretches
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady)    return 0;
      if (roll < 45) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_command(logic [2:0] op, logic [31:0] value);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op    <= op;
      req_ch.value <= value;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      display_sb.note_command(op, value);
      if (op >= OP_SPARE_FIRST)
         commands_ignored++;
      else
         commands_sent++;
   endtask

   task automatic send_random_command();
      logic [2:0]  op;
      logic [31:0] value;
      logic [7:0]  pin;
      int unsigned roll;
      roll  = $urandom_range(0, 99);
      value = $urandom();
      if (roll < 8)
         op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      else
         op = 3'($urandom_range(ssme_pkg::OP_MESSAGE, ssme_pkg::OP_VERSION));
      case (op)
         ssme_pkg::OP_NUMBER: begin
            roll = $urandom_range(0, 2);
            if (roll == 0)      value = $urandom_range(0, 99999);
            else if (roll == 1) value = $urandom_range(0, 999);
         end
         ssme_pkg::OP_PIN: begin
            roll = $urandom_range(0, 3);
            if (roll < 2)       pin = 8'($urandom_range(0, 25));
            else if (roll == 2) pin = 8'($urandom_range(240, 255));
            else                pin = 8'($urandom());
            value[7:0] = pin;
         end
         default: ;
      endcase
      send_command(op, value);
   endtask

   // output side: random ready pattern, plus one long hold-off on request
   initial begin
      int unsigned gap;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (hold_pending) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_pending = 1'b0;
            hold_seen    = 1'b1;
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin
      display_sb       = new();
      cycle_count      = 0;
      commands_sent    = 0;
      commands_ignored = 0;
      steady           = 1'b0;
      hold_pending     = 1'b0;
      hold_seen        = 1'b0;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.op        <= ssme_pkg::OP_MESSAGE;
      req_ch.value     <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, every mode, blank and wrapped codes
      send_command(ssme_pkg::OP_MESSAGE, 32'h0000_0000);
      send_command(ssme_pkg::OP_MESSAGE, 32'hFFFF_FFFF);
      send_command(ssme_pkg::OP_MESSAGE, {2'b00, 6'd63, 6'd42, 6'd15, 6'd12, 6'd41});
      send_command(ssme_pkg::OP_MESSAGE, {2'b11, 6'd40, 6'd33, 6'd20, 6'd16, 6'd11});
      send_command(ssme_pkg::OP_NUMBER, 32'd0);
      send_command(ssme_pkg::OP_NUMBER, 32'd99999);
      send_command(ssme_pkg::OP_NUMBER, 32'd100000);
      send_command(ssme_pkg::OP_NUMBER, 32'd12345);
      send_command(ssme_pkg::OP_NUMBER, 32'hFFFF_FFFF);
      send_command(ssme_pkg::OP_ERROR, 32'd0);
      send_command(ssme_pkg::OP_ERROR, 32'd99);
      send_command(ssme_pkg::OP_ERROR, 32'hFFFF_FFFF);
      send_command(ssme_pkg::OP_PIN, 32'd0);
      send_command(ssme_pkg::OP_PIN, 32'd25);
      send_command(ssme_pkg::OP_PIN, 32'd26);
      send_command(ssme_pkg::OP_PIN, 32'd239);
      send_command(ssme_pkg::OP_PIN, 32'd240);
      send_command(ssme_pkg::OP_PIN, 32'hFFFF_FFFF);
      send_command(ssme_pkg::OP_VERSION, 32'd0);
      send_command(ssme_pkg::OP_VERSION, 32'd100);
      send_command(ssme_pkg::OP_VERSION, 32'hFFFF_FFFF);
      send_command(OP_SPARE_FIRST, 32'hFFFF_FFFF);
      send_command(OP_SPARE_MID, 32'h0000_0000);
      send_command(OP_SPARE_LAST, 32'h5A5A_A5A5);
      send_command(ssme_pkg::OP_MESSAGE, 32'h1234_5678);

      for (int n = 0; n < RANDOM_CMDS; n++) begin
         if (n == 60)  hold_pending = 1'b1;
         if (n == 150) steady = 1'b1;
         if (n == 200) steady = 1'b0;
         send_random_command();
      end
      req_ch.valid <= 1'b0;

      while (display_sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d display commands and %0d ignored commands sent, %0d bytes checked",
               commands_sent, commands_ignored, display_sb.bytes_checked);
      $display("output hold-off with input back-pressure exercised: %0b", hold_seen);
      if (display_sb.mismatches == 0)
         $display("seven_segment_message_encoder regression: pass");
      else
         $display("seven_segment_message_encoder regression: fail");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
design/ssme_pkg.sv
design/ssme_req_if.sv
design/ssme_rsp_if.sv
design/ssme_front.sv
design/ssme_digits.sv
design/ssme_glyph.sv
design/ssme_serializer.sv
design/seven_segment_message_encoder.sv
verif/tb.sv
